### sv/i2cm_pkg.sv
// Package: shared widths, field layout and result struct for the I2C master bit engine.
package i2cm_pkg;

	localparam int CmdW   = 3;
	localparam int ByteW  = 8;
	localparam int UnitW  = 16;
	localparam int TmoW   = 8;
	localparam int DlyW   = 19;
	localparam int CfgAW  = 2;
	localparam int InW    = 16;
	localparam int OutW   = 16;

	localparam logic [UnitW-1:0] UnitTicksRst  = 16'd100;
	localparam logic [TmoW-1:0]  AckTimeoutRst = 8'd250;

	localparam logic [CmdW-1:0] CmdNone  = 3'd0;
	localparam logic [CmdW-1:0] CmdStart = 3'd1;
	localparam logic [CmdW-1:0] CmdStop  = 3'd2;
	localparam logic [CmdW-1:0] CmdWrite = 3'd3;
	localparam logic [CmdW-1:0] CmdRead  = 3'd4;
	localparam logic [CmdW-1:0] CmdWack  = 3'd5;

	localparam logic [CfgAW-1:0] RegUnitTicks  = 2'd0;
	localparam logic [CfgAW-1:0] RegAckTimeout = 2'd1;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [ByteW-1:0] wr_byte;
		logic             send_ack;
		logic             sda_in;
	} item_t;

	typedef struct packed {
		logic             scl_out;
		logic             sda_out;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] rx_byte;
		logic             ack_error;
	} res_t;

endpackage

### sv/i2cm_core.sv
// Core: bus phase sequencer, delay counter and shift registers, one step per beat.
module i2cm_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  i2cm_pkg::item_t              item,
	input  logic [i2cm_pkg::UnitW-1:0]   unit_ticks,
	input  logic [i2cm_pkg::TmoW-1:0]    ack_timeout,
	output i2cm_pkg::res_t               res
);

	localparam logic [3:0] PhIdle = 4'd0;
	localparam logic [3:0] PhStA  = 4'd1;
	localparam logic [3:0] PhStB  = 4'd2;
	localparam logic [3:0] PhSpA  = 4'd3;
	localparam logic [3:0] PhSpB  = 4'd4;
	localparam logic [3:0] PhWrA  = 4'd5;
	localparam logic [3:0] PhWrB  = 4'd6;
	localparam logic [3:0] PhWrC  = 4'd7;
	localparam logic [3:0] PhRdA  = 4'd8;
	localparam logic [3:0] PhRdB  = 4'd9;
	localparam logic [3:0] PhAkA  = 4'd10;
	localparam logic [3:0] PhAkB  = 4'd11;
	localparam logic [3:0] PhWaA  = 4'd12;
	localparam logic [3:0] PhWaB  = 4'd13;
	localparam logic [3:0] PhWaP  = 4'd14;

	logic [3:0]                    phase_q, phase_d;
	logic [i2cm_pkg::DlyW-1:0]     dly_q, dly_d, dly_tick, dly_1, dly_2, dly_4;
	logic [3:0]                    bit_q, bit_d, bit_inc;
	logic [i2cm_pkg::ByteW-1:0]    shift_q, shift_d;
	logic [i2cm_pkg::TmoW-1:0]     poll_q, poll_d;
	logic [i2cm_pkg::ByteW-1:0]    rx_q, rx_d;
	logic                          scl_q, scl_d, sda_q, sda_d, err_q, err_d, ack_q, ack_d;
	logic                          expired, done_d;
	logic [i2cm_pkg::UnitW-1:0]    unit_eff;

	assign unit_eff = (unit_ticks == '0) ? i2cm_pkg::UnitW'(1) : unit_ticks;
	assign dly_1    = {{(i2cm_pkg::DlyW-i2cm_pkg::UnitW){1'b0}}, unit_eff};
	assign dly_2    = dly_1 << 1;
	assign dly_4    = dly_1 << 2;
	assign expired  = (dly_q <= i2cm_pkg::DlyW'(1));
	assign dly_tick = expired ? '0 : dly_q - i2cm_pkg::DlyW'(1);
	assign bit_inc  = bit_q + 4'd1;

	always_comb begin
		phase_d = phase_q;
		dly_d   = dly_tick;
		bit_d   = bit_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		rx_d    = rx_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		err_d   = err_q;
		ack_d   = ack_q;
		done_d  = 1'b0;
		unique case (phase_q)
			PhIdle: begin
				dly_d = dly_q;
				unique case (item.cmd)
					i2cm_pkg::CmdStart: begin
						sda_d = 1'b1; scl_d = 1'b1; dly_d = dly_4; phase_d = PhStA;
					end
					i2cm_pkg::CmdStop: begin
						scl_d = 1'b0; sda_d = 1'b0; dly_d = dly_4; phase_d = PhSpA;
					end
					i2cm_pkg::CmdWrite: begin
						shift_d = item.wr_byte; bit_d = 4'd0;
						scl_d = 1'b0; sda_d = item.wr_byte[i2cm_pkg::ByteW-1];
						dly_d = dly_2; phase_d = PhWrA;
					end
					i2cm_pkg::CmdRead: begin
						ack_d = item.send_ack; shift_d = '0; bit_d = 4'd0;
						sda_d = 1'b1; scl_d = 1'b0; dly_d = dly_2; phase_d = PhRdA;
					end
					i2cm_pkg::CmdWack: begin
						poll_d = '0; sda_d = 1'b1; dly_d = dly_1; phase_d = PhWaA;
					end
					default: ;
				endcase
			end
			PhStA: if (expired) begin
				sda_d = 1'b0; dly_d = dly_4; phase_d = PhStB;
			end
			PhStB: if (expired) begin
				scl_d = 1'b0; phase_d = PhIdle; done_d = 1'b1;
			end
			PhSpA: if (expired) begin
				scl_d = 1'b1; sda_d = 1'b1; dly_d = dly_4; phase_d = PhSpB;
			end
			PhSpB: if (expired) begin
				phase_d = PhIdle; done_d = 1'b1;
			end
			PhWrA: if (expired) begin
				scl_d = 1'b1; dly_d = dly_2; phase_d = PhWrB;
			end
			PhWrB: if (expired) begin
				scl_d = 1'b0; dly_d = dly_2; phase_d = PhWrC;
			end
			PhWrC: if (expired) begin
				bit_d = bit_inc;
				if (bit_inc >= 4'd8) begin
					phase_d = PhIdle; done_d = 1'b1;
				end else begin
					shift_d = {shift_q[i2cm_pkg::ByteW-2:0], 1'b0};
					sda_d   = shift_q[i2cm_pkg::ByteW-2];
					dly_d   = dly_2; phase_d = PhWrA;
				end
			end
			PhRdA: if (expired) begin
				scl_d = 1'b1;
				shift_d = {shift_q[i2cm_pkg::ByteW-2:0], item.sda_in};
				dly_d = dly_1; phase_d = PhRdB;
			end
			PhRdB: if (expired) begin
				bit_d = bit_inc; scl_d = 1'b0; dly_d = dly_2;
				if (bit_inc >= 4'd8) begin
					rx_d = shift_q; sda_d = ~ack_q; phase_d = PhAkA;
				end else begin
					phase_d = PhRdA;
				end
			end
			PhAkA: if (expired) begin
				scl_d = 1'b1; dly_d = dly_2; phase_d = PhAkB;
			end
			PhAkB: if (expired) begin
				scl_d = 1'b0; phase_d = PhIdle; done_d = 1'b1;
			end
			PhWaA: if (expired) begin
				scl_d = 1'b1; dly_d = dly_1; phase_d = PhWaB;
			end
			PhWaB: if (expired) begin
				phase_d = PhWaP;
			end
			PhWaP: begin
				dly_d = dly_q;
				if (poll_q >= ack_timeout) begin
					err_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
					dly_d = dly_4; phase_d = PhSpA;
				end else begin
					poll_d = poll_q + i2cm_pkg::TmoW'(1);
					if (!item.sda_in) begin
						scl_d = 1'b0; err_d = 1'b0; phase_d = PhIdle; done_d = 1'b1;
					end
				end
			end
			default: begin
				dly_d = dly_q; phase_d = PhIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			dly_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			rx_q    <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
			ack_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			dly_q   <= dly_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			poll_q  <= poll_d;
			rx_q    <= rx_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			err_q   <= err_d;
			ack_q   <= ack_d;
		end
	end

	assign res.scl_out   = scl_d;
	assign res.sda_out   = sda_d;
	assign res.busy_res  = (phase_d != PhIdle);
	assign res.done_res  = done_d;
	assign res.rx_byte   = rx_d;
	assign res.ack_error = err_d;

endmodule

### sv/i2c_master_bit_engine.sv
// Top level: input register, I2C step core, result register and configuration registers.
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | s_axis_tvalid/tready       | s_axis_tdata: cmd, wr_byte, send_ack, sda_in
//  m_axis    | out | m_axis_tvalid/tready       | m_axis_tdata: scl, sda, busy, done, rx, err
//  cfg       | in  | cfg_we                     | cfg_addr, cfg_data
//
// One beat in and one out per cycle unless m_axis stalls; each beat passes both registers in turn.
// The input register and the result register each hold one beat; the core steps once per beat.
// A stall on m_axis holds both registers and the core; s_axis_tready drops once both are full.
// arst_n clears the core to idle with both bus lines released, and empties both registers.
module i2c_master_bit_engine #(
	parameter logic [i2cm_pkg::UnitW-1:0] UNIT_TICKS_RST  = i2cm_pkg::UnitTicksRst,
	parameter logic [i2cm_pkg::TmoW-1:0]  ACK_TIMEOUT_RST = i2cm_pkg::AckTimeoutRst
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [i2cm_pkg::InW-1:0]      s_axis_tdata,  // cmd wr_byte send_ack sda_in
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [i2cm_pkg::OutW-1:0] m_axis_tdata, // scl_out sda_out busy_res done_res rx_byte ack_error
	input  logic                          cfg_we,
	input  logic [i2cm_pkg::CfgAW-1:0]    cfg_addr,
	input  logic [i2cm_pkg::UnitW-1:0]    cfg_data
);

	logic                          v_s1, adv, out_v_q;
	i2cm_pkg::item_t               item_s1;
	i2cm_pkg::res_t                res_c, res_q;
	logic [i2cm_pkg::UnitW-1:0]    unit_q;
	logic [i2cm_pkg::TmoW-1:0]     tmo_q;

	assign adv           = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_TICKS_RST;
			tmo_q  <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_addr == i2cm_pkg::RegUnitTicks) unit_q <= cfg_data;
			if (cfg_addr == i2cm_pkg::RegAckTimeout) tmo_q <= cfg_data[i2cm_pkg::TmoW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd      <= s_axis_tdata[2:0];
			item_s1.wr_byte  <= s_axis_tdata[10:3];
			item_s1.send_ack <= s_axis_tdata[11];
			item_s1.sda_in   <= s_axis_tdata[12];
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.item        (item_s1),
		.unit_ticks  (unit_q),
		.ack_timeout (tmo_q),
		.res         (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, res_q.ack_error, res_q.rx_byte, res_q.done_res,
		res_q.busy_res, res_q.sda_out, res_q.scl_out};

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done beat still busy");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_v_q)
		else $error("stepped beat lost");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule
